// ----- rtl/tlog_pkg.sv -----
// package for the thermistor lookup over-temperature guard
// holds the adc threshold table, vdrop offset table and shared types
// no dependencies
package tlog_pkg;

    localparam int StoredEntries = 152;
    localparam int TableEntriesDefault = 152;
    localparam int AdcWidth = 10;
    localparam int CelsiusBase = -30;
    localparam int VdropBias = 66;
    localparam int FahrMul = 9;
    localparam int FahrDiv = 5;
    localparam int FahrOfs = 32;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDataWidth = 8;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_HOT_ON   = 2'd0,
        CFG_HOT_OFF  = 2'd1,
        CFG_DEBOUNCE = 2'd2
    } cfg_idx_t;

    // word queued between lookup front and guard back
    typedef struct packed {
        logic signed [7:0] celsius;
        logic signed [8:0] fahrenheit;
        logic [6:0]        vdrop;
    } lookup_word_t;

    function automatic logic [9:0] adc_threshold(input int idx);
        logic [9:0] t;
        case (idx)
            0: t = 10'd1000; 1: t = 10'd997; 2: t = 10'd994; 3: t = 10'd991;
            4: t = 10'd987; 5: t = 10'd984; 6: t = 10'd981; 7: t = 10'd977;
            8: t = 10'd974; 9: t = 10'd971; 10: t = 10'd967; 11: t = 10'd963;
            12: t = 10'd957; 13: t = 10'd952; 14: t = 10'd947; 15: t = 10'd941;
            16: t = 10'd936; 17: t = 10'd931; 18: t = 10'd925; 19: t = 10'd920;
            20: t = 10'd915; 21: t = 10'd909; 22: t = 10'd904; 23: t = 10'd898;
            24: t = 10'd892; 25: t = 10'd887; 26: t = 10'd881; 27: t = 10'd875;
            28: t = 10'd869; 29: t = 10'd864; 30: t = 10'd858; 31: t = 10'd852;
            32: t = 10'd845; 33: t = 10'd836; 34: t = 10'd828; 35: t = 10'd819;
            36: t = 10'd810; 37: t = 10'd801; 38: t = 10'd792; 39: t = 10'd784;
            40: t = 10'd775; 41: t = 10'd766; 42: t = 10'd756; 43: t = 10'd746;
            44: t = 10'd736; 45: t = 10'd726; 46: t = 10'd716; 47: t = 10'd706;
            48: t = 10'd691; 49: t = 10'd685; 50: t = 10'd675; 51: t = 10'd665;
            52: t = 10'd654; 53: t = 10'd644; 54: t = 10'd634; 55: t = 10'd623;
            56: t = 10'd613; 57: t = 10'd602; 58: t = 10'd592; 59: t = 10'd577;
            60: t = 10'd572; 61: t = 10'd562; 62: t = 10'd552; 63: t = 10'd542;
            64: t = 10'd533; 65: t = 10'd523; 66: t = 10'd513; 67: t = 10'd503;
            68: t = 10'd493; 69: t = 10'd483; 70: t = 10'd472; 71: t = 10'd462;
            72: t = 10'd451; 73: t = 10'd440; 74: t = 10'd430; 75: t = 10'd419;
            76: t = 10'd408; 77: t = 10'd398; 78: t = 10'd387; 79: t = 10'd382;
            80: t = 10'd369; 81: t = 10'd360; 82: t = 10'd352; 83: t = 10'd343;
            84: t = 10'd334; 85: t = 10'd326; 86: t = 10'd317; 87: t = 10'd309;
            88: t = 10'd300; 89: t = 10'd292; 90: t = 10'd283; 91: t = 10'd274;
            92: t = 10'd266; 93: t = 10'd257; 94: t = 10'd249; 95: t = 10'd241;
            96: t = 10'd235; 97: t = 10'd229; 98: t = 10'd223; 99: t = 10'd217;
            100: t = 10'd208; 101: t = 10'd205; 102: t = 10'd200; 103: t = 10'd196;
            104: t = 10'd191; 105: t = 10'd184; 106: t = 10'd181; 107: t = 10'd176;
            108: t = 10'd172; 109: t = 10'd167; 110: t = 10'd162; 111: t = 10'd158;
            112: t = 10'd154; 113: t = 10'd150; 114: t = 10'd146; 115: t = 10'd142;
            116: t = 10'd138; 117: t = 10'd134; 118: t = 10'd131; 119: t = 10'd127;
            120: t = 10'd122; 121: t = 10'd120; 122: t = 10'd117; 123: t = 10'd115;
            124: t = 10'd112; 125: t = 10'd108; 126: t = 10'd106; 127: t = 10'd103;
            128: t = 10'd101; 129: t = 10'd98; 130: t = 10'd95; 131: t = 10'd92;
            132: t = 10'd89; 133: t = 10'd87; 134: t = 10'd84; 135: t = 10'd81;
            136: t = 10'd79; 137: t = 10'd77; 138: t = 10'd75; 139: t = 10'd73;
            140: t = 10'd71; 141: t = 10'd69; 142: t = 10'd67; 143: t = 10'd65;
            144: t = 10'd63; 145: t = 10'd61; 146: t = 10'd59; 147: t = 10'd57;
            148: t = 10'd55; 149: t = 10'd53; 150: t = 10'd51; 151: t = 10'd49;
            default: t = 10'd0;
        endcase
        return t;
    endfunction

    function automatic logic signed [7:0] vdrop_offset(input int idx);
        logic signed [7:0] v;
        case (idx)
            0, 1: v = 8'sd28; 2: v = 8'sd27; 3, 4: v = 8'sd26; 5: v = 8'sd25;
            6, 7: v = 8'sd24; 8, 9: v = 8'sd23; 10: v = 8'sd22; 11, 12: v = 8'sd21;
            13: v = 8'sd20; 14, 15: v = 8'sd19; 16, 17: v = 8'sd18; 18: v = 8'sd17;
            19, 20: v = 8'sd16; 21: v = 8'sd15; 22, 23: v = 8'sd14;
            24, 25: v = 8'sd13; 26: v = 8'sd12; 27, 28: v = 8'sd11;
            29, 30: v = 8'sd10; 31: v = 8'sd9; 32, 33: v = 8'sd8; 34: v = 8'sd7;
            35: v = 8'sd6; 36: v = 8'sd5; 37: v = 8'sd4; 38, 39: v = 8'sd3;
            40, 41: v = 8'sd2; 42, 43: v = 8'sd1; 44: v = 8'sd0;
            45: v = -8'sd1; 46: v = -8'sd2; 47: v = -8'sd3; 48: v = -8'sd4;
            49: v = -8'sd5; 50: v = -8'sd6; 51: v = -8'sd7; 52: v = -8'sd8;
            53: v = -8'sd9; 54: v = -8'sd10; 55: v = -8'sd11;
            56, 57, 58: v = -8'sd12; 59, 60, 61: v = -8'sd13;
            62, 63, 64: v = -8'sd14; 65, 66, 67: v = -8'sd15;
            68, 69, 70, 71: v = -8'sd16; 72, 73: v = -8'sd17; 74, 75: v = -8'sd18;
            76: v = -8'sd19; 77, 78: v = -8'sd20; 79: v = -8'sd21;
            80, 81: v = -8'sd22; 82, 83: v = -8'sd23; 84: v = -8'sd24;
            85, 86: v = -8'sd25; 87, 88: v = -8'sd30; 89: v = -8'sd31;
            90, 91: v = -8'sd32; 92: v = -8'sd33; 93, 94: v = -8'sd34;
            95, 96: v = -8'sd35; 97: v = -8'sd36; 98, 99: v = -8'sd37;
            100: v = -8'sd38; 101: v = -8'sd39; 102: v = -8'sd29;
            103, 104: v = -8'sd40; 105: v = -8'sd41; 106, 107: v = -8'sd42;
            108: v = -8'sd43; 109, 110: v = -8'sd44; 111, 112: v = -8'sd45;
            113: v = -8'sd46; 114, 115: v = -8'sd47; 116, 117: v = -8'sd48;
            118: v = -8'sd49; 119, 120: v = -8'sd50; 121: v = -8'sd51;
            122, 123: v = -8'sd52; 124, 125: v = -8'sd53; 126: v = -8'sd54;
            127, 128: v = -8'sd55;
            default: v = -8'sd56;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/tlog_stream_if.sv -----
// valid/ready stream interface carrying a parameterized payload
// depends on nothing
interface tlog_stream_if #(
    parameter int Width = 10
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tlog_lookup.sv -----
// front part: table priority decode and unit conversion into a result queue
// depends on tlog_pkg
module tlog_lookup #(
    parameter int TableEntries = tlog_pkg::TableEntriesDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [9:0]            adc_sample,
    output logic                  q_valid,
    input  logic                  q_ready,
    output tlog_pkg::lookup_word_t q_word
);
    localparam int N = (TableEntries > tlog_pkg::StoredEntries) ?
                       tlog_pkg::StoredEntries : TableEntries;
    localparam int IdxW = $clog2(tlog_pkg::StoredEntries);

    logic [IdxW-1:0] idx;
    logic signed [9:0] cel_w;
    logic signed [13:0] c9;
    logic signed [13:0] mag;
    logic [13:0] quo;
    logic signed [9:0] fah_w;
    logic signed [8:0] vd_w;
    tlog_pkg::lookup_word_t word_in;

    // two-entry queue
    tlog_pkg::lookup_word_t buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic       push, pop;

    // priority decode, first match wins
    always_comb
    begin
        idx = IdxW'(N - 1);
        for (int i = N - 2; i >= 0; i--)
        begin
            if (adc_sample >= tlog_pkg::adc_threshold(i))
            begin
                idx = IdxW'(i);
            end
        end
    end

    // divide by 5 toward zero on the magnitude: (m*3277)>>14 exact for any 14-bit m
    always_comb
    begin
        cel_w = 10'(signed'({2'b00, idx})) + 10'(tlog_pkg::CelsiusBase);
        c9 = 14'(cel_w) * 14'(tlog_pkg::FahrMul);
        mag = c9[13] ? -c9 : c9;
        quo = 14'((24'(mag) * 24'd3277) >> 14);
        fah_w = c9[13] ? -10'(quo) : 10'(quo);
        fah_w = fah_w + 10'(tlog_pkg::FahrOfs);
        vd_w = 9'(tlog_pkg::vdrop_offset(int'(idx))) + 9'(tlog_pkg::VdropBias);
        word_in.celsius = cel_w[7:0];
        word_in.fahrenheit = fah_w[8:0];
        word_in.vdrop = vd_w[6:0];
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_word = buf_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        rd_next = pop ? ~rd_reg : rd_reg;
        wr_next = push ? ~wr_reg : wr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg <= rd_next;
            wr_reg <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= word_in;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready) else $error("accept while full");
    a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> rd_reg == wr_reg)
        else $error("queue pointers out of step");
endmodule

// ----- rtl/tlog_guard.sv -----
// back part: debounced over-temperature flag, fault latch and output register
// depends on tlog_pkg
module tlog_guard (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  tlog_pkg::lookup_word_t q_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            temp_celsius,
    output logic [8:0]            temp_fahrenheit,
    output logic [6:0]            vdrop_correction,
    output logic                  over_temp,
    output logic                  fault_raise,
    output logic                  fault_clear
);
    logic signed [7:0] hot_on_reg, hot_off_reg;
    logic [7:0] limit_reg;
    logic       flag_reg, flag_next, latch_reg, latch_next;
    logic [7:0] on_reg, on_next, off_reg, off_next;
    logic       valid_reg;
    logic       take, raise_w, clear_w;
    logic signed [7:0] c;

    assign q_ready = !valid_reg || out_ready;
    assign take = q_valid && q_ready;
    assign c = q_word.celsius;
    assign out_valid = valid_reg;

    always_comb
    begin
        flag_next = flag_reg;
        on_next = on_reg;
        off_next = off_reg;
        // set step before clear step
        if (c >= hot_on_reg && !flag_next)
        begin
            on_next = on_reg + 8'd1;
            if (on_reg >= limit_reg)
            begin
                flag_next = 1'b1;
                off_next = '0;
            end
        end
        if (flag_next && c <= hot_off_reg)
        begin
            off_next = off_next + 8'd1;
            if (off_next - 8'd1 >= limit_reg)
            begin
                flag_next = 1'b0;
                on_next = '0;
            end
        end
        raise_w = flag_next && !latch_reg;
        clear_w = !flag_next;
        latch_next = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hot_on_reg <= 8'sd85;
            hot_off_reg <= 8'sd75;
            limit_reg <= 8'd10;
            flag_reg <= 1'b0;
            latch_reg <= 1'b0;
            on_reg <= '0;
            off_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tlog_pkg::CFG_HOT_ON: hot_on_reg <= cfg_data;
                    tlog_pkg::CFG_HOT_OFF: hot_off_reg <= cfg_data;
                    tlog_pkg::CFG_DEBOUNCE: limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (take)
            begin
                flag_reg <= flag_next;
                latch_reg <= latch_next;
                on_reg <= on_next;
                off_reg <= off_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            temp_celsius <= q_word.celsius;
            temp_fahrenheit <= q_word.fahrenheit;
            vdrop_correction <= q_word.vdrop;
            over_temp <= flag_next;
            fault_raise <= raise_w;
            fault_clear <= clear_w;
        end
    end

    a_latch_follows: assert property (@(posedge clk) disable iff (!rst_n)
        latch_reg == flag_reg) else $error("fault latch diverged from flag");
    a_raise_excl: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !(fault_raise && fault_clear)) else $error("raise and clear");
    a_raise_edge: assert property (@(posedge clk) disable iff (!rst_n)
        take && raise_w |=> flag_reg && !$past(flag_reg)) else $error("raise not edge");
endmodule

// ----- rtl/thermistor_lookup_overtemp_guard_unit.sv -----
// top level of the thermistor lookup over-temperature guard
// depends on tlog_pkg, tlog_stream_if, tlog_lookup, tlog_guard
//
// one adc word in, one result word out per accepted sample, one word per
// cycle sustained while result_out stays ready; the front decodes the
// constant threshold table and converts units in the accept cycle into a
// two-word queue, the back updates the debounce counters and fault latch
// and holds the result in an output register, so an accepted sample passes
// the queue and then the output register before output valid rises.
// configuration registers take effect on the next sample processed by the
// back and should only be written while idle
module thermistor_lookup_overtemp_guard_unit #(
    parameter int TableEntries = tlog_pkg::TableEntriesDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    tlog_stream_if.sink   sample_in,
    tlog_stream_if.source result_out
);
    logic                   q_valid, q_ready;
    tlog_pkg::lookup_word_t q_word;

    // result word packing: celsius, fahrenheit, vdrop, flag, raise, clear
    logic [7:0] celsius;
    logic [8:0] fahrenheit;
    logic [6:0] vdrop;
    logic       ot, fr, fc;

    tlog_lookup #(.TableEntries(TableEntries)) u_lookup (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample_in.valid),
        .in_ready   (sample_in.ready),
        .adc_sample (sample_in.data[9:0]),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_word     (q_word)
    );

    tlog_guard u_guard (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_word           (q_word),
        .out_valid        (result_out.valid),
        .out_ready        (result_out.ready),
        .temp_celsius     (celsius),
        .temp_fahrenheit  (fahrenheit),
        .vdrop_correction (vdrop),
        .over_temp        (ot),
        .fault_raise      (fr),
        .fault_clear      (fc)
    );

    assign result_out.data = {fc, fr, ot, vdrop, fahrenheit, celsius};
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for thermistor_lookup_overtemp_guard_unit
// needs tlog_pkg, tlog_stream_if and the unit itself
module tb;

    // index with no register behind it, writes to it must be dropped
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int ResultWidth = 27;
    localparam int Entries = 152;
    localparam int Latency = 4;

    // one result word as the unit packs it, first field in the top bits
    typedef struct packed {
        logic              fault_clear;
        logic              fault_raise;
        logic              over_temp;
        logic [6:0]        vdrop;
        logic signed [8:0] fahrenheit;
        logic signed [7:0] celsius;
    } guard_word_t;

    // directed row: the temperatures are typed in only where obvious
    typedef struct {
        logic [9:0] adc;
        bit         typed;
        int         celsius;
        int         fahrenheit;
        int         vdrop;
    } adc_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    tlog_stream_if #(.Width(10)) sample_if ();
    tlog_stream_if #(.Width(ResultWidth)) result_if ();

    thermistor_lookup_overtemp_guard_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_if.sink),
        .result_out (result_if.source)
    );

    always #6 clk = ~clk;

    // threshold and offset per entry, entry i is i - 30 celsius
    int adc_thr [0:Entries-1] = '{
        1000, 997, 994, 991, 987, 984, 981, 977, 974, 971,
        967, 963, 957, 952, 947, 941, 936, 931, 925, 920,
        915, 909, 904, 898, 892, 887, 881, 875, 869, 864,
        858, 852, 845, 836, 828, 819, 810, 801, 792, 784,
        775, 766, 756, 746, 736, 726, 716, 706, 691, 685,
        675, 665, 654, 644, 634, 623, 613, 602, 592, 577,
        572, 562, 552, 542, 533, 523, 513, 503, 493, 483,
        472, 462, 451, 440, 430, 419, 408, 398, 387, 382,
        369, 360, 352, 343, 334, 326, 317, 309, 300, 292,
        283, 274, 266, 257, 249, 241, 235, 229, 223, 217,
        208, 205, 200, 196, 191, 184, 181, 176, 172, 167,
        162, 158, 154, 150, 146, 142, 138, 134, 131, 127,
        122, 120, 117, 115, 112, 108, 106, 103, 101, 98,
        95, 92, 89, 87, 84, 81, 79, 77, 75, 73,
        71, 69, 67, 65, 63, 61, 59, 57, 55, 53,
        51, 49};
    int vd_ofs [0:Entries-1] = '{
        28, 28, 27, 26, 26, 25, 24, 24, 23, 23,
        22, 21, 21, 20, 19, 19, 18, 18, 17, 16,
        16, 15, 14, 14, 13, 13, 12, 11, 11, 10,
        10, 9, 8, 8, 7, 6, 5, 4, 3, 3,
        2, 2, 1, 1, 0, -1, -2, -3, -4, -5,
        -6, -7, -8, -9, -10, -11, -12, -12, -12, -13,
        -13, -13, -14, -14, -14, -15, -15, -15, -16, -16,
        -16, -16, -17, -17, -18, -18, -19, -20, -20, -21,
        -22, -22, -23, -23, -24, -25, -25, -30, -30, -31,
        -32, -32, -33, -34, -34, -35, -35, -36, -37, -37,
        -38, -39, -29, -40, -40, -41, -42, -42, -43, -44,
        -44, -45, -45, -46, -47, -47, -48, -48, -49, -50,
        -50, -51, -52, -52, -53, -53, -54, -55, -55, -56,
        -56, -56, -56, -56, -56, -56, -56, -56, -56, -56,
        -56, -56, -56, -56, -56, -56, -56, -56, -56, -56,
        -56, -56};

    // shadow of the guard registers and state
    logic signed [7:0] hot_on_c;
    logic signed [7:0] hot_off_c;
    logic [7:0] deb_limit;
    logic hot_flag;
    logic [7:0] on_cnt;
    logic [7:0] off_cnt;
    logic fault_held;

    guard_word_t pending_words [$];
    int errors = 0;
    bit idle_en = 1'b1;
    int rx_stall = 0;

    // lookup plus debounce, advances the shadow state by one sample
    function automatic guard_word_t guard_sample(logic [9:0] adc);
        guard_word_t w;
        int idx;
        int c;
        bit hit;
        idx = 0;
        while (idx < Entries - 1 && int'(adc) < adc_thr[idx])
            idx++;
        c = idx - 30;
        w.celsius = 8'(c);
        w.fahrenheit = 9'((c * 9) / 5 + 32);
        w.vdrop = 7'(66 + vd_ofs[idx]);
        // set step goes first, clear may follow on the same sample
        if (c >= hot_on_c && !hot_flag) begin
            hit = on_cnt >= deb_limit;
            on_cnt = on_cnt + 8'd1;
            if (hit) begin
                hot_flag = 1'b1;
                off_cnt = '0;
            end
        end
        if (hot_flag && c <= hot_off_c) begin
            hit = off_cnt >= deb_limit;
            off_cnt = off_cnt + 8'd1;
            if (hit) begin
                hot_flag = 1'b0;
                on_cnt = '0;
            end
        end
        w.fault_raise = hot_flag && !fault_held;
        w.fault_clear = !hot_flag;
        fault_held = hot_flag;
        w.over_temp = hot_flag;
        return w;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            tlog_pkg::CFG_HOT_ON:   hot_on_c = val;
            tlog_pkg::CFG_HOT_OFF:  hot_off_c = val;
            tlog_pkg::CFG_DEBOUNCE: deb_limit = val;
            default: ;
        endcase
    endtask

    // push one word, optionally after an idle burst; valid stays high otherwise
    task automatic send_sample(logic [9:0] adc, bit typed = 0, int c = 0, int f = 0,
                               int vd = 0);
        guard_word_t w;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.data <= adc;
        @(posedge clk);
        while (!sample_if.ready) @(posedge clk);
        w = guard_sample(adc);
        if (typed) begin
            w.celsius = 8'(c);
            w.fahrenheit = 9'(f);
            w.vdrop = 7'(vd);
        end
        pending_words.push_back(w);
    endtask

    task automatic drain();
        sample_if.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (Latency) @(posedge clk);
    endtask

    // adc value that lands on the entry for celsius c
    function automatic logic [9:0] adc_for(int c);
        int idx;
        idx = c + 30;
        if (idx <= 0) return 10'($urandom_range(1000, 1023));
        if (idx >= Entries - 1 && $urandom_range(0, 1)) return 10'($urandom_range(0, 50));
        return 10'($urandom_range(adc_thr[idx], adc_thr[idx-1] - 1));
    endfunction

    // receive side: check every accepted word, then choose ready
    always @(posedge clk) begin
        guard_word_t got;
        guard_word_t want;
        if (rst_n && result_if.valid && result_if.ready) begin
            got = result_if.data;
            if (pending_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch c %0d/%0d f %0d/%0d vd %0d/%0d flags %b%b%b/%b%b%b",
                                 want.celsius, got.celsius, want.fahrenheit, got.fahrenheit,
                                 want.vdrop, got.vdrop, want.over_temp, want.fault_raise,
                                 want.fault_clear, got.over_temp, got.fault_raise,
                                 got.fault_clear);
                end
            end
        end
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            result_if.ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            rx_stall <= $urandom_range(0, 17);
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    adc_row_t adc_rows [22] = '{
        '{10'd1023, 1, -30, -22, 94},
        '{10'd1000, 1, -30, -22, 94},
        '{10'd999, 1, -29, -20, 94},
        '{10'd51, 1, 120, 248, 10},
        '{10'd0, 1, 121, 249, 10},
        '{10'd50, 1, 121, 249, 10},
        '{10'd49, 1, 121, 249, 10},
        '{10'd0, 0, 0, 0, 0}, '{10'd0, 0, 0, 0, 0}, '{10'd0, 0, 0, 0, 0},
        '{10'd0, 0, 0, 0, 0}, '{10'd0, 0, 0, 0, 0}, '{10'd0, 0, 0, 0, 0},
        '{10'd0, 0, 0, 0, 0}, '{10'd0, 0, 0, 0, 0}, '{10'd0, 0, 0, 0, 0},
        '{10'd512, 0, 0, 0, 0},
        '{10'd700, 0, 0, 0, 0},
        '{10'd300, 0, 0, 0, 0},
        '{10'd1023, 0, 0, 0, 0},
        '{10'd341, 0, 0, 0, 0},
        '{10'd682, 0, 0, 0, 0}
    };

    // settings per random phase: hot_on, hot_off, debounce
    int phase_on [0:7] = '{85, -30, 121, 50, 0, 100, 121, 60};
    int phase_off [0:7] = '{75, 121, -30, 60, -10, 20, 121, -30};
    int phase_deb [0:7] = '{10, 0, 255, 3, 1, 5, 2, 0};

    initial begin
        int hot_c;
        int cold_c;
        int run_len;
        int c;
        sample_if.valid = 1'b0;
        sample_if.data = '0;
        hot_on_c = 8'sd85;
        hot_off_c = 8'sd75;
        deb_limit = 8'd10;
        hot_flag = 1'b0;
        on_cnt = '0;
        off_cnt = '0;
        fault_held = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a write to the spare index must leave the defaults alone
        write_reg(CFG_UNUSED, 8'h00);
        foreach (adc_rows[i])
            send_sample(adc_rows[i].adc, adc_rows[i].typed, adc_rows[i].celsius,
                        adc_rows[i].fahrenheit, adc_rows[i].vdrop);
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p >= 6) begin
                phase_on[p] = $urandom_range(0, 151) - 30;
                phase_off[p] = $urandom_range(0, 151) - 30;
                phase_deb[p] = $urandom_range(0, 6);
            end
            write_reg(tlog_pkg::CFG_HOT_ON, 8'(phase_on[p]));
            write_reg(tlog_pkg::CFG_HOT_OFF, 8'(phase_off[p]));
            write_reg(tlog_pkg::CFG_DEBOUNCE, 8'(phase_deb[p]));
            if (p == 7) idle_en = 1'b0;
            // runs of hot or cold samples drive the debounce both ways
            for (int n = 0; n < 55; ) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_sample(10'($urandom_range(0, 1023)));
                    n++;
                end else begin
                    run_len = $urandom_range(1, (deb_limit < 12 ? deb_limit : 12) + 3);
                    hot_c = $urandom_range(0, 1);
                    for (int k = 0; k < run_len && n < 55; k++, n++) begin
                        if (hot_c) begin
                            c = hot_on_c > -30 ? hot_on_c : -30;
                            c = $urandom_range(c + 30, 151) - 30;
                        end else begin
                            cold_c = hot_off_c < 121 ? hot_off_c : 121;
                            c = cold_c < -30 ? -30 : $urandom_range(0, cold_c + 30) - 30;
                        end
                        send_sample(adc_for(c));
                    end
                end
            end
            drain();
        end

        if (errors == 0 && pending_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog well past the slowest legal run
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/tlog_pkg.sv
rtl/tlog_stream_if.sv
rtl/tlog_lookup.sv
rtl/tlog_guard.sv
rtl/thermistor_lookup_overtemp_guard_unit.sv
tb/sv/tb.sv
